FILE: rtl/qndt_pkg.sv
// Shared types and constants for the quartic negative definite test unit.
package qndt_pkg;

    // Limb width of the partial-product multipliers (33x33 signed cells).
    localparam int LIMB_W = 32;

    typedef enum logic [1:0] {
        MODE_ALL = 2'd0,
        MODE_POS = 2'd1,
        MODE_NEG = 2'd2
    } t_mode;

    // Stage enables of one pipelined multiplier.
    typedef struct packed {
        logic pp;
        logic row;
        logic sum;
    } t_mul_en;

endpackage

FILE: rtl/qndt_mul.sv
// Three-stage pipelined signed multiplier built from limb partial products.
module qndt_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                       i_clk,
    input  qndt_pkg::t_mul_en          i_en,
    input  logic signed [AW-1:0]       i_a,
    input  logic signed [BW-1:0]       i_b,
    output logic signed [AW+BW-1:0]    o_p
);
    import qndt_pkg::*;

    localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
    localparam int AX  = NA * LIMB_W;
    localparam int BX  = NB * LIMB_W;
    localparam int PW  = AW + BW;
    localparam int SW  = AX + BX + 2;
    localparam int LW  = LIMB_W + 1;
    localparam int PPW = 2 * LW;

    logic signed [AX-1:0]  a_x;
    logic signed [BX-1:0]  b_x;
    logic signed [LW-1:0]  a_l [NA];
    logic signed [LW-1:0]  b_l [NB];
    logic signed [PPW-1:0] n_pp [NA][NB];
    logic signed [PPW-1:0] r_pp [NA][NB];
    logic signed [SW-1:0]  n_row [NA];
    logic signed [SW-1:0]  r_row [NA];
    logic signed [SW-1:0]  n_sum;
    logic signed [SW-1:0]  r_sum;

    assign a_x = AX'(i_a);
    assign b_x = BX'(i_b);

    // low limbs unsigned, top limb carries the sign
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_l[i] = {a_x[AX-1], a_x[i*LIMB_W +: LIMB_W]};
            end else begin
                a_l[i] = {1'b0, a_x[i*LIMB_W +: LIMB_W]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_l[j] = {b_x[BX-1], b_x[j*LIMB_W +: LIMB_W]};
            end else begin
                b_l[j] = {1'b0, b_x[j*LIMB_W +: LIMB_W]};
            end
        end
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i][j] = a_l[i] * b_l[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (SW'(r_pp[i][j]) <<< (j * LIMB_W));
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] <<< (i * LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.pp) begin
            r_pp <= n_pp;
        end
        if (i_en.row) begin
            r_row <= n_row;
        end
        if (i_en.sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_p = PW'(r_sum);

endmodule

FILE: rtl/quartic_negative_definite_test_unit.sv
// Top level of the quartic negative definite test: invariant and sample-screen pipeline.
// Throughput: one word per cycle while i_out_ready holds; 13 register stages, each holding one word,
// with three chained three-stage multiplier levels (pairwise products,
// I^2 with the J and Q parts, I^3 and J^2) setting the depth.
// Ready ripples back through per-stage valid bits, so bubbles are squeezed out.
// Reset (synchronous, active low) clears only the stage valid bits.
module quartic_negative_definite_test_unit #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_mode,
    input  logic signed [COEF_WIDTH-1:0] i_coef_x4,
    input  logic signed [COEF_WIDTH-1:0] i_coef_x3,
    input  logic signed [COEF_WIDTH-1:0] i_coef_x2,
    input  logic signed [COEF_WIDTH-1:0] i_coef_x1,
    input  logic signed [COEF_WIDTH-1:0] i_coef_x0,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_negative_definite
);
    import qndt_pkg::*;

    // ---------------------------------------------------------------
    // Widths. Bounds: |product of two coefs| <= 2^(2W-2).
    // ---------------------------------------------------------------
    localparam int W   = COEF_WIDTH;
    localparam int EW  = W + 10;       // sample values, |f| <= 341*2^(W-1)
    localparam int PW1 = 2 * W;        // pairwise products
    localparam int IW  = 2 * W + 4;    // I, |I| <= 2^(2W+2)
    localparam int XW  = 2 * W + 6;    // 72ae + 9bd - 2cc
    localparam int HW  = 2 * W + 3;    // H = 8ac - 3bb
    localparam int CPW = 2 * W + 1;    // cc + bd
    localparam int JW  = 3 * W + 6;    // J
    localparam int QW  = 4 * W + 4;    // Q
    localparam int DW  = 6 * W + 12;   // disc

    // Pipeline stage map
    localparam int NST    = 13;
    localparam int ST_IN  = 0;         // coefficient register, sample screen
    localparam int ST_L1  = 1;         // first multiplier level, stages 1..3
    localparam int ST_C1  = 4;         // I, X, H, cc+bd
    localparam int ST_L2  = 5;         // second multiplier level, stages 5..7
    localparam int ST_C2  = 8;         // J, Q sign
    localparam int ST_L3  = 9;         // third multiplier level, stages 9..11
    localparam int ST_OUT = 12;        // disc sign, result word

    // First-level product slots
    localparam int P_AA = 0;
    localparam int P_AE = 1;
    localparam int P_AC = 2;
    localparam int P_BB = 3;
    localparam int P_BD = 4;
    localparam int P_CC = 5;
    localparam int P_DD = 6;
    localparam int NP1  = 7;

    typedef struct packed {
        logic                pre;     // every cheap check of the mode passed
        logic                all;     // mode needs the invariant checks
        logic signed [W-1:0] a;
        logic signed [W-1:0] c;
        logic signed [W-1:0] e;
    } t_sb1;

    typedef struct packed {
        logic                 pre;
        logic                 all;
        logic                 hge;    // H >= 0
        logic signed [IW-1:0] i;
    } t_sb2;

    typedef struct packed {
        logic pre;
        logic all;
        logic okq;                    // H >= 0 or Q <= 0
    } t_sb3;

    // ---------------------------------------------------------------
    // Handshake: a stage advances when empty or when the next one advances.
    // ---------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[ST_IN];
    assign o_out_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[ST_IN]) begin
                r_vld[ST_IN] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------
    t_mode               r_mode;
    logic signed [W-1:0] r_a;
    logic signed [W-1:0] r_b;
    logic signed [W-1:0] r_c;
    logic signed [W-1:0] r_d;
    logic signed [W-1:0] r_e;

    always_ff @(posedge i_clk) begin
        if (adv[ST_IN]) begin
            r_mode <= t_mode'(i_mode);
            r_a    <= i_coef_x4;
            r_b    <= i_coef_x3;
            r_c    <= i_coef_x2;
            r_d    <= i_coef_x1;
            r_e    <= i_coef_x0;
        end
    end

    // Sample screen and the f(1), f(-1) checks; odd coefficients flip for x<=0.
    logic signed [EW-1:0] ax, bx, cx, dx, ex, bs, ds;
    logic signed [EW-1:0] f_p1, f_m1, g1, g2, gh, g3, g4;
    logic                 neg_ae;
    logic                 scr_ok;
    t_sb1                 n_sb1;

    always_comb begin
        ax   = EW'(r_a);
        bx   = EW'(r_b);
        cx   = EW'(r_c);
        dx   = EW'(r_d);
        ex   = EW'(r_e);
        bs   = (r_mode == MODE_NEG) ? -bx : bx;
        ds   = (r_mode == MODE_NEG) ? -dx : dx;
        f_p1 = ax + bx + cx + dx + ex;
        f_m1 = ax - bx + cx - dx + ex;
        g1   = ax + bs + cx + ds + ex;
        g2   = (ax <<< 4) + (bs <<< 3) + (cx <<< 2) + (ds <<< 1) + ex;
        gh   = ax + (bs <<< 1) + (cx <<< 2) + (ds <<< 3) + (ex <<< 4);   // 16*f(1/2)
        g3   = ax * EW'(81) + bs * EW'(27) + cx * EW'(9) + ds * EW'(3) + ex;
        g4   = (ax <<< 8) + (bs <<< 6) + (cx <<< 4) + (ds <<< 2) + ex;
        neg_ae = r_a[W-1] && r_e[W-1];
        scr_ok = g1[EW-1] && g2[EW-1] && gh[EW-1] && g3[EW-1] && g4[EW-1];

        n_sb1.a = r_a;
        n_sb1.c = r_c;
        n_sb1.e = r_e;
        case (r_mode)
            MODE_ALL: begin
                n_sb1.pre = neg_ae && f_p1[EW-1] && f_m1[EW-1];
                n_sb1.all = 1'b1;
            end
            MODE_POS, MODE_NEG: begin
                n_sb1.pre = neg_ae && scr_ok;
                n_sb1.all = 1'b0;
            end
            default: begin
                n_sb1.pre = 1'b0;
                n_sb1.all = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Stages 1..3: pairwise coefficient products
    // ---------------------------------------------------------------
    t_mul_en               en_l1;
    logic signed [W-1:0]   l1_x [NP1];
    logic signed [W-1:0]   l1_y [NP1];
    logic signed [PW1-1:0] l1_p [NP1];
    t_sb1                  r_sb1 [3];

    assign en_l1 = '{pp: adv[ST_L1], row: adv[ST_L1+1], sum: adv[ST_L1+2]};

    assign l1_x[P_AA] = r_a;  assign l1_y[P_AA] = r_a;
    assign l1_x[P_AE] = r_a;  assign l1_y[P_AE] = r_e;
    assign l1_x[P_AC] = r_a;  assign l1_y[P_AC] = r_c;
    assign l1_x[P_BB] = r_b;  assign l1_y[P_BB] = r_b;
    assign l1_x[P_BD] = r_b;  assign l1_y[P_BD] = r_d;
    assign l1_x[P_CC] = r_c;  assign l1_y[P_CC] = r_c;
    assign l1_x[P_DD] = r_d;  assign l1_y[P_DD] = r_d;

    for (genvar g = 0; g < NP1; g++) begin : g_l1
        qndt_mul #(.AW(W), .BW(W)) u_mul (
            .i_clk (i_clk),
            .i_en  (en_l1),
            .i_a   (l1_x[g]),
            .i_b   (l1_y[g]),
            .o_p   (l1_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_L1]) begin
            r_sb1[0] <= n_sb1;
        end
        for (int k = 1; k < 3; k++) begin
            if (adv[ST_L1+k]) begin
                r_sb1[k] <= r_sb1[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: I, X = 72ae + 9bd - 2cc, H sign, cc + bd
    // ---------------------------------------------------------------
    logic signed [IW-1:0]  n_i;
    logic signed [XW-1:0]  n_x;
    logic signed [HW-1:0]  n_h;
    logic signed [CPW-1:0] n_cp;
    t_sb2                  n_sb2;

    logic signed [XW-1:0]  r_x;
    logic signed [CPW-1:0] r_cp;
    logic signed [PW1-1:0] r_aa, r_ae, r_bb, r_ac, r_dd;
    logic signed [W-1:0]   r_a4, r_c4, r_e4;
    t_sb2                  r_s4;

    always_comb begin
        n_i  = IW'(l1_p[P_AE]) * IW'(12) - IW'(l1_p[P_BD]) * IW'(3) + IW'(l1_p[P_CC]);
        n_x  = XW'(l1_p[P_AE]) * XW'(72) + XW'(l1_p[P_BD]) * XW'(9)
             - (XW'(l1_p[P_CC]) <<< 1);
        n_h  = (HW'(l1_p[P_AC]) <<< 3) - HW'(l1_p[P_BB]) * HW'(3);
        n_cp = CPW'(l1_p[P_CC]) + CPW'(l1_p[P_BD]);
        n_sb2.pre = r_sb1[2].pre;
        n_sb2.all = r_sb1[2].all;
        n_sb2.hge = !n_h[HW-1];
        n_sb2.i   = n_i;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_C1]) begin
            r_s4 <= n_sb2;
            r_x  <= n_x;
            r_cp <= n_cp;
            r_aa <= l1_p[P_AA];
            r_ae <= l1_p[P_AE];
            r_bb <= l1_p[P_BB];
            r_ac <= l1_p[P_AC];
            r_dd <= l1_p[P_DD];
            r_a4 <= r_sb1[2].a;
            r_c4 <= r_sb1[2].c;
            r_e4 <= r_sb1[2].e;
        end
    end

    // ---------------------------------------------------------------
    // Stages 5..7: I^2, the parts of J and the parts of Q
    // ---------------------------------------------------------------
    t_mul_en                    en_l2;
    logic signed [2*IW-1:0]     p_ii;
    logic signed [W+XW-1:0]     p_cx;
    logic signed [W+PW1-1:0]    p_add;
    logic signed [W+PW1-1:0]    p_ebb;
    logic signed [2*PW1-1:0]    p_b4;
    logic signed [PW1+CPW-1:0]  p_acp;
    logic signed [2*PW1-1:0]    p_acb;
    logic signed [2*PW1-1:0]    p_aae;
    t_sb2                       r_sb2 [3];

    assign en_l2 = '{pp: adv[ST_L2], row: adv[ST_L2+1], sum: adv[ST_L2+2]};

    qndt_mul #(.AW(IW), .BW(IW)) u_ii (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_s4.i), .i_b (r_s4.i), .o_p (p_ii)
    );
    qndt_mul #(.AW(W), .BW(XW)) u_cx (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_c4), .i_b (r_x), .o_p (p_cx)
    );
    qndt_mul #(.AW(W), .BW(PW1)) u_add (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_a4), .i_b (r_dd), .o_p (p_add)
    );
    qndt_mul #(.AW(W), .BW(PW1)) u_ebb (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_e4), .i_b (r_bb), .o_p (p_ebb)
    );
    qndt_mul #(.AW(PW1), .BW(PW1)) u_b4 (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_bb), .i_b (r_bb), .o_p (p_b4)
    );
    qndt_mul #(.AW(PW1), .BW(CPW)) u_acp (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_aa), .i_b (r_cp), .o_p (p_acp)
    );
    qndt_mul #(.AW(PW1), .BW(PW1)) u_acb (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_ac), .i_b (r_bb), .o_p (p_acb)
    );
    qndt_mul #(.AW(PW1), .BW(PW1)) u_aae (
        .i_clk (i_clk), .i_en (en_l2), .i_a (r_aa), .i_b (r_ae), .o_p (p_aae)
    );

    always_ff @(posedge i_clk) begin
        if (adv[ST_L2]) begin
            r_sb2[0] <= r_s4;
        end
        for (int k = 1; k < 3; k++) begin
            if (adv[ST_L2+k]) begin
                r_sb2[k] <= r_sb2[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: J = c*X - 27(a*dd + e*bb), sign of Q
    // Q = 3 b^4 + 16(aa(cc+bd) - ac*bb) - 64 aa*ae
    // ---------------------------------------------------------------
    logic signed [JW-1:0]   n_j;
    logic signed [QW-1:0]   n_q;
    t_sb3                   n_sb3;
    logic signed [JW-1:0]   r_j;
    logic signed [2*IW-1:0] r_i2;
    logic signed [IW-1:0]   r_i8;
    t_sb3                   r_s8;

    always_comb begin
        n_j = JW'(p_cx) - JW'(27) * (JW'(p_add) + JW'(p_ebb));
        n_q = QW'(p_b4) * QW'(3) + ((QW'(p_acp) - QW'(p_acb)) <<< 4)
            - (QW'(p_aae) <<< 6);
        n_sb3.pre = r_sb2[2].pre;
        n_sb3.all = r_sb2[2].all;
        n_sb3.okq = r_sb2[2].hge || n_q[QW-1] || (n_q == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_C2]) begin
            r_j  <= n_j;
            r_i2 <= p_ii;
            r_i8 <= r_sb2[2].i;
            r_s8 <= n_sb3;
        end
    end

    // ---------------------------------------------------------------
    // Stages 9..11: I^3 and J^2
    // ---------------------------------------------------------------
    t_mul_en              en_l3;
    logic signed [DW-1:0] p_i3;
    logic signed [DW-1:0] p_jj;
    t_sb3                 r_sb3 [3];

    assign en_l3 = '{pp: adv[ST_L3], row: adv[ST_L3+1], sum: adv[ST_L3+2]};

    qndt_mul #(.AW(2*IW), .BW(IW)) u_i3 (
        .i_clk (i_clk), .i_en (en_l3), .i_a (r_i2), .i_b (r_i8), .o_p (p_i3)
    );
    qndt_mul #(.AW(JW), .BW(JW)) u_jj (
        .i_clk (i_clk), .i_en (en_l3), .i_a (r_j), .i_b (r_j), .o_p (p_jj)
    );

    always_ff @(posedge i_clk) begin
        if (adv[ST_L3]) begin
            r_sb3[0] <= r_s8;
        end
        for (int k = 1; k < 3; k++) begin
            if (adv[ST_L3+k]) begin
                r_sb3[k] <= r_sb3[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 12: disc = 4 I^3 - J^2 > 0, final word
    // ---------------------------------------------------------------
    logic signed [DW-1:0] disc;
    logic                 disc_pos;
    logic                 n_res;
    logic                 r_res;

    always_comb begin
        disc     = (p_i3 <<< 2) - p_jj;
        disc_pos = !disc[DW-1] && (disc != '0);
        n_res    = r_sb3[2].pre && (!r_sb3[2].all || (disc_pos && r_sb3[2].okq));
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r_res <= n_res;
        end
    end

    assign o_negative_definite = r_res;

`ifndef SYNTHESIS
    // input held off only when every stage holds a word
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // any pass needs a < 0 and e < 0
    a_pre_needs_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_L1] && r_sb1[0].pre |-> r_sb1[0].a[W-1] && r_sb1[0].e[W-1])
        else $error("pass flag set with a or e nonnegative");

    // a word in the last multiplier stage reaches the output when it advances
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_OUT-1] && adv[ST_OUT] |=> o_out_valid)
        else $error("word lost between last multiplier stage and output");
`endif

endmodule
